FILE: src/dfr_pkg.sv
// Shared types, constants and helpers for the sync-then-length-prefixed deframer.
// Used by dfr_front, dfr_fifo, dfr_back and the top level; depends on nothing.
package dfr_pkg;

    // Signature window and its fixed text
    localparam int SIG_LEN      = 36;
    localparam int SIG_TEXT_LEN = 36;
    localparam logic [8*SIG_TEXT_LEN-1:0] SIG_TEXT = "0c63fba6-7c2a-4b72-8de0-b3bd579dedaa";

    // Window fill count holds 0..SIG_LEN, window index holds 0..SIG_LEN-1
    localparam int CNT_W  = $clog2(SIG_LEN + 1);
    localparam int WIN_IW = (SIG_LEN > 1) ? $clog2(SIG_LEN) : 1;

    localparam logic [7:0] LINE_FEED = 8'h0A;

    // Binary header: four little-endian 32-bit words
    localparam int HDR_BYTES = 16;
    localparam int HCNT_W    = $clog2(HDR_BYTES);
    localparam int LEFT_W    = 31;

    // Queue between front and back (depth is a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef enum logic [2:0] {
        K_TEXT    = 3'd0,
        K_SYNC    = 3'd1,
        K_HEADER  = 3'd2,
        K_PAYLOAD = 3'd3,
        K_BAD     = 3'd4
    } t_kind;

    // One queued result, fields not used by its kind are cleared by the back end
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [3:0][31:0] words;
        logic             last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Signature byte at a window position; positions past the text compare against zero
    function automatic logic [7:0] sig_byte(input int i);
        logic [7:0] b;
        b = 8'h00;
        if (i < SIG_TEXT_LEN) begin
            b = SIG_TEXT[8*(SIG_TEXT_LEN-1-i) +: 8];
        end
        return b;
    endfunction

endpackage

FILE: src/sync_then_length_prefixed_deframer.sv
// Top level of the sync-then-length-prefixed deframer: front end, result queue
// and output back end. Depends on dfr_pkg, dfr_front, dfr_fifo and dfr_back.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_in_byte
//   result    out        o_valid / i_ready   o_kind .. o_last
//
// One byte per cycle in text, header and payload modes while the queue has room;
// each result passes through the queue and then the output register. A line
// feed that does not close the signature holds input while the window drains.
// Reset (synchronous, active low) returns to text mode with an empty window and queue.
// Output stalls back up through the two-entry queue; input stalls once it is full.
module sync_then_length_prefixed_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_in_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic signed [31:0] o_packet_type,
    output logic signed [31:0] o_source_id,
    output logic signed [31:0] o_destination_id,
    output logic signed [31:0] o_payload_length,
    output logic               o_last
);
    import dfr_pkg::*;

    logic    q_push;
    logic    q_pop;
    t_entry  q_in;
    t_entry  q_out;
    t_q_stat q_stat;

    dfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .o_push    (q_push),
        .o_entry   (q_in),
        .i_q_stat  (q_stat)
    );

    dfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_stat  (q_stat)
    );

    dfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (q_out),
        .i_q_stat         (q_stat),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_packet_type    (o_packet_type),
        .o_source_id      (o_source_id),
        .o_destination_id (o_destination_id),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

`ifndef SYNTH
    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("result pushed into full queue");

    // Bad length always closes the stream
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_BAD)) |-> o_last)
        else $error("bad length result without last mark");

    // Nothing follows a transferred bad-length result
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && (o_kind == K_BAD)) |=> !o_valid)
        else $error("result after bad length");
`endif

endmodule

FILE: src/dfr_front.sv
// Front end: accepts stream bytes, keeps the line window, header and payload count,
// and pushes classified results into the queue. Depends on dfr_pkg.
module dfr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_in_byte,
    output logic             o_push,
    output dfr_pkg::t_entry  o_entry,
    input  dfr_pkg::t_q_stat i_q_stat
);
    import dfr_pkg::*;

    typedef enum logic [2:0] {
        S_TEXT,
        S_FLUSH,
        S_HDR,
        S_PAY,
        S_HALT
    } t_state;

    t_state                  r_state, n_state;
    logic [7:0]              r_win [SIG_LEN];
    logic [7:0]              n_win [SIG_LEN];
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [8*HDR_BYTES-1:0]  r_hdr, n_hdr;
    logic [HCNT_W-1:0]       r_hcnt, n_hcnt;
    logic [LEFT_W-1:0]       r_left, n_left;

    logic                    accept;
    logic                    match;
    logic [8*HDR_BYTES-1:0]  hdr_asm;
    logic [3:0][31:0]        hdr_words;

    // Ready: halted bytes are taken and dropped, flush blocks input
    assign o_ready = (r_state == S_HALT) || ((r_state != S_FLUSH) && !i_q_stat.full);
    assign accept  = i_valid && o_ready;

    // Header bytes shift in from the top; the first byte ends at the bottom
    assign hdr_asm   = {i_in_byte, r_hdr[8*HDR_BYTES-1:8]};
    assign hdr_words = hdr_asm;

    // Full window equal to the signature
    always_comb begin
        match = (r_cnt == CNT_W'(SIG_LEN));
        for (int i = 0; i < SIG_LEN; i++) begin
            if (r_win[i] != sig_byte(i)) begin
                match = 1'b0;
            end
        end
    end

    // Next state and queue push
    always_comb begin
        n_state = r_state;
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_hdr   = r_hdr;
        n_hcnt  = r_hcnt;
        n_left  = r_left;
        o_push  = 1'b0;
        o_entry.kind  = K_TEXT;
        o_entry.data  = i_in_byte;
        o_entry.words = hdr_words;
        o_entry.last  = 1'b0;

        unique case (r_state)
            S_TEXT: begin
                if (accept) begin
                    if (i_in_byte == LINE_FEED) begin
                        if (match) begin
                            o_push       = 1'b1;
                            o_entry.kind = K_SYNC;
                            o_entry.last = 1'b1;
                            n_cnt        = '0;
                            n_hcnt       = '0;
                            n_left       = '0;
                            n_state      = S_HDR;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end else if (r_cnt == CNT_W'(SIG_LEN)) begin
                        // window full: oldest byte leaves as text
                        o_push       = 1'b1;
                        o_entry.data = r_win[0];
                        for (int i = 0; i < SIG_LEN - 1; i++) begin
                            n_win[i] = r_win[i+1];
                        end
                        n_win[SIG_LEN-1] = i_in_byte;
                    end else begin
                        n_win[r_cnt[WIN_IW-1:0]] = i_in_byte;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                // one window byte per cycle while the queue has room, then the line feed
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    if (r_cnt != '0) begin
                        o_entry.data = r_win[0];
                        for (int i = 0; i < SIG_LEN - 1; i++) begin
                            n_win[i] = r_win[i+1];
                        end
                        n_cnt = r_cnt - CNT_W'(1);
                    end else begin
                        o_entry.data = LINE_FEED;
                        o_entry.last = 1'b1;
                        n_state      = S_TEXT;
                    end
                end
            end
            S_HDR: begin
                if (accept) begin
                    n_hdr = hdr_asm;
                    if (r_hcnt == HCNT_W'(HDR_BYTES - 1)) begin
                        n_hcnt = '0;
                        o_push = 1'b1;
                        if (hdr_words[3][31]) begin
                            o_entry.kind = K_BAD;
                            o_entry.last = 1'b1;
                            n_state      = S_HALT;
                        end else begin
                            o_entry.kind = K_HEADER;
                            o_entry.last = (hdr_words[3] == 32'd0);
                            n_left       = hdr_words[3][LEFT_W-1:0];
                            n_state      = (hdr_words[3] == 32'd0) ? S_HDR : S_PAY;
                        end
                    end else begin
                        n_hcnt = r_hcnt + HCNT_W'(1);
                    end
                end
            end
            S_PAY: begin
                if (accept) begin
                    o_push       = 1'b1;
                    o_entry.kind = K_PAYLOAD;
                    n_left       = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        o_entry.last = 1'b1;
                        n_state      = S_HDR;
                    end
                end
            end
            S_HALT: begin
            end
            default: begin
                n_state = S_HALT;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_hdr <= n_hdr;
        if (!i_rst_n) begin
            r_state <= S_TEXT;
            r_cnt   <= '0;
            r_hcnt  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_hcnt  <= n_hcnt;
            r_left  <= n_left;
        end
    end

endmodule

FILE: src/dfr_fifo.sv
// Short result queue between the front and back ends.
// Depends on dfr_pkg for the entry type and depth.
module dfr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dfr_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output dfr_pkg::t_entry  o_entry,
    output dfr_pkg::t_q_stat o_stat
);
    import dfr_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_entry      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/dfr_back.sv
// Back end: pops queued results, clears fields unused by each kind and holds
// them in the output register until transfer. Depends on dfr_pkg.
module dfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfr_pkg::t_entry    i_entry,
    input  dfr_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic signed [31:0] o_packet_type,
    output logic signed [31:0] o_source_id,
    output logic signed [31:0] o_destination_id,
    output logic signed [31:0] o_payload_length,
    output logic               o_last
);
    import dfr_pkg::*;

    logic             r_valid;
    logic [2:0]       r_kind;
    logic [7:0]       r_data;
    logic [3:0][31:0] r_words;
    logic             r_last;
    logic             has_data;
    logic             has_words;

    assign o_pop     = !i_q_stat.empty && (!r_valid || i_ready);
    assign has_data  = (i_entry.kind == K_TEXT) || (i_entry.kind == K_PAYLOAD);
    assign has_words = (i_entry.kind == K_HEADER) || (i_entry.kind == K_BAD);

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_entry.kind;
            r_data  <= has_data ? i_entry.data : 8'h00;
            r_words <= has_words ? i_entry.words : '0;
            r_last  <= i_entry.last;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_packet_type    = r_words[0];
    assign o_source_id      = r_words[1];
    assign o_destination_id = r_words[2];
    assign o_payload_length = r_words[3];
    assign o_last           = r_last;

endmodule
